// ----- design/fixed_width_number_to_ascii_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the number formatter
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_WIDTH_NUMBER_TO_ASCII_ASSERT_SVH
`define FIXED_WIDTH_NUMBER_TO_ASCII_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FWNA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FWNA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/fwna_pkg.sv -----
// ----------------------------------------------------------------------------
// Number formatter package
// Field widths, mode codes, character codes, the queued descriptor type and
// the helper functions for decimal conversion and digit selection.
// ----------------------------------------------------------------------------
`default_nettype none

package fwna_pkg;

    localparam int FUNC_W = 2;
    localparam int NUM_W  = 32;
    localparam int CNT_W  = 6;
    localparam int LINE_W = 3;
    localparam int SCOL_W = 5;
    localparam int CHAR_W = 7;
    localparam int COL_W  = 6;

    localparam int MAX_DIGITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH        = 2;

    localparam int BCD_DIGITS    = 10;
    localparam int HEX_DIGITS    = NUM_W / 4;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = NUM_W / BITS_PER_STEP;
    localparam int ITER_W        = $clog2(CONV_STEPS);

    typedef enum logic [FUNC_W-1:0] {
        MODE_UDEC = 2'd0,
        MODE_SDEC = 2'd1,
        MODE_HEX  = 2'd2,
        MODE_BIN  = 2'd3
    } mode_t;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CONV,
        B_SIGN,
        B_DIGIT
    } back_state_t;

    typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

    typedef struct packed {
        mode_t              mode;
        logic               neg;
        logic [NUM_W-1:0]   mag;
        logic [CNT_W-1:0]   count;
        logic [LINE_W-1:0]  line;
        logic [COL_W-1:0]   col;
    } desc_t;

    function automatic bcd_t dabble_step(input bcd_t b, input logic bit_in);
        bcd_t                    adj;
        logic [4*BCD_DIGITS:0]   shifted;
        adj = b;
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (adj[k] >= 4'd5)
            begin
                adj[k] = adj[k] + 4'd3;
            end
        end
        shifted = {adj, bit_in};
        return shifted[4*BCD_DIGITS-1:0];
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(
        input mode_t             mode,
        input logic [NUM_W-1:0]  value,
        input bcd_t              bcd,
        input logic [CNT_W-1:0]  place
    );
        logic [HEX_DIGITS-1:0][3:0] nibs;
        logic [3:0]                 d;
        logic [CHAR_W-1:0]          ch;
        nibs = value;
        d    = 4'd0;
        ch   = CH_ZERO;
        case (mode)
            MODE_HEX:
            begin
                if (place < CNT_W'(HEX_DIGITS))
                begin
                    d  = nibs[place[$clog2(HEX_DIGITS)-1:0]];
                    ch = (d < 4'd10) ? CH_ZERO + CHAR_W'(d) : CH_A + CHAR_W'(d - 4'd10);
                end
            end
            MODE_BIN:
            begin
                if (place < CNT_W'(NUM_W))
                begin
                    ch = CH_ZERO + CHAR_W'(value[place[$clog2(NUM_W)-1:0]]);
                end
            end
            default:
            begin
                if (place < CNT_W'(BCD_DIGITS))
                begin
                    ch = CH_ZERO + CHAR_W'(bcd[place[$clog2(BCD_DIGITS)-1:0]]);
                end
            end
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- design/fwna_if.sv -----
// ----------------------------------------------------------------------------
// Number formatter channels
// Valid/ready channels for the number words and the character words.
// ----------------------------------------------------------------------------
`default_nettype none

interface fwna_item_if;
    import fwna_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [NUM_W-1:0]  number;
    logic [CNT_W-1:0]  digit_count;
    logic [LINE_W-1:0] text_line;
    logic [SCOL_W-1:0] start_column;

    modport source (output valid, func, number, digit_count, text_line, start_column,
                    input ready);
    modport sink   (input valid, func, number, digit_count, text_line, start_column,
                    output ready);
endinterface

interface fwna_text_if;
    import fwna_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic [LINE_W-1:0] line_pos;
    logic [COL_W-1:0]  column_pos;
    logic              last_char;

    modport source (output valid, char_code, line_pos, column_pos, last_char,
                    input ready);
    modport sink   (input valid, char_code, line_pos, column_pos, last_char,
                    output ready);
endinterface

`default_nettype wire

// ----- design/fwna_front.sv -----
// ----------------------------------------------------------------------------
// Number formatter front end
// Accepts number words, saturates the digit count, takes the magnitude of
// signed values and pushes a descriptor into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fwna_front #(
    parameter int MAX_DIGITS = fwna_pkg::MAX_DIGITS_DEFAULT
) (
    fwna_item_if.sink        item,
    input  wire logic        q_full,
    output logic             push,
    output fwna_pkg::desc_t  push_desc
);
    import fwna_pkg::*;

    logic [CNT_W-1:0] count_sat;
    logic             neg;

    assign item.ready = !q_full;
    assign push       = item.valid && !q_full;

    always_comb
    begin
        count_sat = (item.digit_count > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
                                                            : item.digit_count;
        neg = (mode_t'(item.func) == MODE_SDEC) && item.number[NUM_W-1];
        push_desc.mode  = mode_t'(item.func);
        push_desc.neg   = neg;
        push_desc.mag   = neg ? (NUM_W'(0) - item.number) : item.number;
        push_desc.count = count_sat;
        push_desc.line  = item.text_line;
        push_desc.col   = {1'b0, item.start_column};
    end

endmodule

`default_nettype wire

// ----- design/fwna_queue.sv -----
// ----------------------------------------------------------------------------
// Number formatter descriptor queue
// Short register FIFO between the front end and the character engine.
// ----------------------------------------------------------------------------
`default_nettype none

module fwna_queue #(
    parameter int DEPTH = fwna_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire fwna_pkg::desc_t  push_desc,
    output logic                  full,
    input  wire logic             pop,
    output fwna_pkg::desc_t       pop_desc,
    output logic                  empty
);
    import fwna_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    desc_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full     = (fill_reg == FILL_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_desc = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

// ----- design/fwna_back.sv -----
// ----------------------------------------------------------------------------
// Number formatter character engine
// Converts decimal magnitudes to BCD four bits a cycle, then emits the sign
// of signed decimal words and the digits through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fwna_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_empty,
    input  wire fwna_pkg::desc_t  q_desc,
    output logic                  pop,
    fwna_text_if.source           text
);
    import fwna_pkg::*;

    back_state_t        state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic               neg_reg, neg_next;
    logic [NUM_W-1:0]   mag_reg, mag_next;
    bcd_t               bcd_reg, bcd_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   place_reg, place_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic [COL_W-1:0]   col_reg, col_next;

    logic               ov_reg, ov_next;
    logic [CHAR_W-1:0]  och_reg, och_next;
    logic [LINE_W-1:0]  oline_reg, oline_next;
    logic [COL_W-1:0]   ocol_reg, ocol_next;
    logic               olast_reg, olast_next;

    logic               load_ok;
    logic               is_dec;
    bcd_t               bcd_work;

    assign load_ok = !ov_reg || text.ready;
    assign pop     = (state_reg == B_IDLE) && !q_empty;
    assign is_dec  = (q_desc.mode == MODE_UDEC) || (q_desc.mode == MODE_SDEC);

    assign text.valid      = ov_reg;
    assign text.char_code  = och_reg;
    assign text.line_pos   = oline_reg;
    assign text.column_pos = ocol_reg;
    assign text.last_char  = olast_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (is_dec)
                    begin
                        state_next = B_CONV;
                    end
                    else if (q_desc.count != '0)
                    begin
                        state_next = B_DIGIT;
                    end
                end
            end
            B_CONV:
            begin
                if (iter_reg == ITER_W'(CONV_STEPS - 1))
                begin
                    if (mode_reg == MODE_SDEC)
                    begin
                        state_next = B_SIGN;
                    end
                    else if (count_reg != '0)
                    begin
                        state_next = B_DIGIT;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_SIGN:
            begin
                if (load_ok)
                begin
                    state_next = (count_reg == '0) ? B_IDLE : B_DIGIT;
                end
            end
            B_DIGIT:
            begin
                if (load_ok && (place_reg == '0))
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        iter_next  = iter_reg;
        count_next = count_reg;
        place_next = place_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        och_next   = och_reg;
        oline_next = oline_reg;
        ocol_next  = ocol_reg;
        olast_next = olast_reg;
        ov_next    = text.ready ? 1'b0 : ov_reg;
        bcd_work   = bcd_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    mode_next  = q_desc.mode;
                    neg_next   = q_desc.neg;
                    mag_next   = q_desc.mag;
                    bcd_next   = '0;
                    iter_next  = '0;
                    count_next = q_desc.count;
                    place_next = q_desc.count - CNT_W'(1);
                    line_next  = q_desc.line;
                    col_next   = q_desc.col;
                end
            end
            B_CONV:
            begin
                for (int s = 0; s < BITS_PER_STEP; s++)
                begin
                    bcd_work = dabble_step(bcd_work, mag_reg[NUM_W-1-s]);
                end
                bcd_next  = bcd_work;
                mag_next  = mag_reg << BITS_PER_STEP;
                iter_next = iter_reg + ITER_W'(1);
            end
            B_SIGN:
            begin
                if (load_ok)
                begin
                    ov_next    = 1'b1;
                    och_next   = neg_reg ? CH_MINUS : CH_PLUS;
                    oline_next = line_reg;
                    ocol_next  = col_reg;
                    olast_next = (count_reg == '0);
                    col_next   = col_reg + COL_W'(1);
                end
            end
            B_DIGIT:
            begin
                if (load_ok)
                begin
                    ov_next    = 1'b1;
                    och_next   = digit_char(mode_reg, mag_reg, bcd_reg, place_reg);
                    oline_next = line_reg;
                    ocol_next  = col_reg;
                    olast_next = (place_reg == '0);
                    col_next   = col_reg + COL_W'(1);
                    place_next = place_reg - CNT_W'(1);
                end
            end
            default:
            begin
                ov_next = ov_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        bcd_reg   <= bcd_next;
        iter_reg  <= iter_next;
        count_reg <= count_next;
        place_reg <= place_next;
        line_reg  <= line_next;
        col_reg   <= col_next;
        och_reg   <= och_next;
        oline_reg <= oline_next;
        ocol_reg  <= ocol_next;
        olast_reg <= olast_next;
    end

endmodule

`default_nettype wire

// ----- design/fixed_width_number_to_ascii.sv -----
// ----------------------------------------------------------------------------
// Fixed-width number to ASCII formatter
// Turns a 32-bit number into a run of decimal, signed decimal, hex or binary
// characters, each tagged with its text line and column.
// ----------------------------------------------------------------------------
//  Channel | Direction | Word contents
//  item    | in        | func, number, digit_count, text_line, start_column
//  text    | out       | char_code, line_pos, column_pos, last_char
//
// A hex or binary word goes straight from idle to emitting digits in the
// character engine; a decimal word first runs the BCD conversion that shifts
// in four bits a cycle, and a signed decimal word then emits its sign.
// A two-entry descriptor queue lets new words be taken while a run is emitted.
// Reset clears the queue, the engine state and the output valid; no memory is
// swept. A text stall holds the output register and the sign and digit states.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_width_number_to_ascii #(
    parameter int MAX_DIGITS = fwna_pkg::MAX_DIGITS_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fwna_item_if.sink   item,
    fwna_text_if.source text
);
    import fwna_pkg::*;

    logic  push;
    desc_t push_desc;
    logic  q_full;
    logic  q_empty;
    logic  pop;
    desc_t q_desc;

    fwna_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .item      (item),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    fwna_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .pop_desc  (q_desc),
        .empty     (q_empty)
    );

    fwna_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_desc  (q_desc),
        .pop     (pop),
        .text    (text)
    );

endmodule

`default_nettype wire

// ----- design/fwna_check.sv -----
// ----------------------------------------------------------------------------
// Number formatter port checker
// Watches the character channel for legal codes and consistent runs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fixed_width_number_to_ascii_assert.svh"

module fwna_check (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          valid,
    input wire logic                          ready,
    input wire logic [fwna_pkg::CHAR_W-1:0]   char_code,
    input wire logic [fwna_pkg::LINE_W-1:0]   line_pos,
    input wire logic [fwna_pkg::COL_W-1:0]    column_pos,
    input wire logic                          last_char
);
    import fwna_pkg::*;

    logic                          in_run_reg, in_run_next;
    logic [COL_W-1:0]              prev_col_reg;
    logic [LINE_W-1:0]             prev_line_reg;
    logic                          take;
    logic                          is_digit, is_hex, is_sign;
    logic [CHAR_W+LINE_W+COL_W:0]  word;
    logic                          stall;
    logic                          legal;
    logic                          step_ok;

    assign take     = valid && ready;
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_ZERO + CHAR_W'(9));
    assign is_hex   = (char_code >= CH_A) && (char_code <= CH_A + CHAR_W'(5));
    assign is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS);
    assign word     = {char_code, line_pos, column_pos, last_char};
    assign stall    = valid && !ready;
    assign legal    = is_digit || is_hex || is_sign;
    assign step_ok  = (column_pos == prev_col_reg + COL_W'(1)) && (line_pos == prev_line_reg);

    always_comb
    begin
        in_run_next = in_run_reg;
        if (take)
        begin
            in_run_next = !last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg <= 1'b0;
        end
        else
        begin
            in_run_reg <= in_run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prev_col_reg  <= column_pos;
            prev_line_reg <= line_pos;
        end
    end

    `FWNA_ASSERT_NEXT(a_hold, stall, valid && $stable(word), "Stalled word changed")
    `FWNA_ASSERT_NOW(a_code, valid, legal, "Illegal character code")
    `FWNA_ASSERT_NOW(a_sign_first, take && in_run_reg, !is_sign, "Sign character inside a run")
    `FWNA_ASSERT_NOW(a_run_pos, take && in_run_reg, step_ok, "Run column or line out of step")

endmodule

bind fixed_width_number_to_ascii fwna_check u_fwna_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (text.valid),
    .ready      (text.ready),
    .char_code  (text.char_code),
    .line_pos   (text.line_pos),
    .column_pos (text.column_pos),
    .last_char  (text.last_char)
);

`default_nettype wire

// ----- tb/tb_fixed_width_number_to_ascii.sv -----
// ----------------------------------------------------------------------------
// Testbench for the fixed-width number to ASCII formatter
// Sends number words in all four modes, directed corner words first and then
// random ones. Every accepted word is expanded into the characters it must
// produce. Each character word that leaves the block is checked field by field
// against the oldest character still owed. Both channels idle and stall at
// random, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_fixed_width_number_to_ascii;
    timeunit 1ns;
    timeprecision 1ps;

    import fwna_pkg::*;

    typedef struct {
        mode_t              func;
        logic [NUM_W-1:0]   number;
        logic [CNT_W-1:0]   digit_count;
        logic [LINE_W-1:0]  text_line;
        logic [SCOL_W-1:0]  start_column;
    } number_word_t;

    typedef struct {
        logic [CHAR_W-1:0]  char_code;
        logic [LINE_W-1:0]  line_pos;
        logic [COL_W-1:0]   column_pos;
        logic               last_char;
    } char_word_t;

    localparam int DIGIT_LIMIT = 32;
    localparam int CALM_WORDS  = 30;

    logic clk;
    logic rst_n;

    fwna_item_if item_bus ();
    fwna_text_if text_bus ();

    fixed_width_number_to_ascii #(
        .MAX_DIGITS(DIGIT_LIMIT)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .item (item_bus),
        .text (text_bus)
    );

    number_word_t number_words[$];
    char_word_t   owed_chars[$];
    number_word_t next_word;
    number_word_t taken_word;
    char_word_t   seen_char;
    char_word_t   owed_char;
    logic         item_taken;
    int           send_gap;
    int           recv_stall;
    int           gap_pct;
    int           tick;
    int           mismatches;
    int           failures;

    always #5 clk = ~clk;

    function automatic void format_number(input number_word_t w);
        logic [NUM_W-1:0]  mag;
        logic [NUM_W-1:0]  pow10;
        logic [3:0]        nib;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  col;
        int                count;
        int                place;
        char_word_t        c;
        mag   = w.number;
        count = (w.digit_count > DIGIT_LIMIT) ? DIGIT_LIMIT : int'(w.digit_count);
        col   = COL_W'(w.start_column);
        if (w.func == MODE_SDEC)
        begin
            c.char_code  = w.number[NUM_W-1] ? CH_MINUS : CH_PLUS;
            c.line_pos   = w.text_line;
            c.column_pos = col;
            c.last_char  = (count == 0);
            owed_chars.push_back(c);
            col = col + COL_W'(1);
            if (w.number[NUM_W-1])
            begin
                mag = -w.number;
            end
        end
        for (int i = 0; i < count; i++)
        begin
            place = count - 1 - i;
            ch    = CH_ZERO;
            case (w.func)
                MODE_HEX:
                begin
                    if (place < 8)
                    begin
                        nib = mag[4*place +: 4];
                        ch  = (nib < 4'd10) ? CH_ZERO + CHAR_W'(nib)
                                            : CH_A + CHAR_W'(nib - 4'd10);
                    end
                end
                MODE_BIN:
                begin
                    if (place < NUM_W)
                    begin
                        ch = CH_ZERO + CHAR_W'(mag[place]);
                    end
                end
                default:
                begin
                    if (place < 10)
                    begin
                        pow10 = 1;
                        for (int j = 0; j < place; j++)
                        begin
                            pow10 = pow10 * 10;
                        end
                        ch = CH_ZERO + CHAR_W'((mag / pow10) % 10);
                    end
                end
            endcase
            c.char_code  = ch;
            c.line_pos   = w.text_line;
            c.column_pos = col + COL_W'(i);
            c.last_char  = (i + 1 == count);
            owed_chars.push_back(c);
        end
    endfunction

    task automatic report_char(input string what, input char_word_t exp_c,
                               input char_word_t got_c);
        failures++;
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s: expected %h/%0d/%0d/%0d, got %h/%0d/%0d/%0d",
                     $realtime, what, exp_c.char_code, exp_c.line_pos, exp_c.column_pos,
                     exp_c.last_char, got_c.char_code, got_c.line_pos, got_c.column_pos,
                     got_c.last_char);
        end
    endtask

    task automatic add_word(input mode_t func, input logic [NUM_W-1:0] number,
                            input logic [CNT_W-1:0] digit_count,
                            input logic [LINE_W-1:0] text_line,
                            input logic [SCOL_W-1:0] start_column);
        number_word_t w;
        w.func         = func;
        w.number       = number;
        w.digit_count  = digit_count;
        w.text_line    = text_line;
        w.start_column = start_column;
        number_words.push_back(w);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_taken <= 1'b0;
        end
        else
        begin
            item_taken <= item_bus.valid && item_bus.ready;
            if (item_bus.valid && item_bus.ready)
            begin
                taken_word.func         = mode_t'(item_bus.func);
                taken_word.number       = item_bus.number;
                taken_word.digit_count  = item_bus.digit_count;
                taken_word.text_line    = item_bus.text_line;
                taken_word.start_column = item_bus.start_column;
                format_number(taken_word);
            end
            if (text_bus.valid && text_bus.ready)
            begin
                seen_char.char_code  = text_bus.char_code;
                seen_char.line_pos   = text_bus.line_pos;
                seen_char.column_pos = text_bus.column_pos;
                seen_char.last_char  = text_bus.last_char;
                if (owed_chars.size() == 0)
                begin
                    owed_char = '{default: 'x};
                    report_char("unexpected word", owed_char, seen_char);
                end
                else
                begin
                    owed_char = owed_chars.pop_front();
                    if (seen_char.char_code !== owed_char.char_code
                        || seen_char.line_pos !== owed_char.line_pos
                        || seen_char.column_pos !== owed_char.column_pos
                        || seen_char.last_char !== owed_char.last_char)
                    begin
                        report_char("mismatch", owed_char, seen_char);
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            tick <= tick + 1;
            if (tick % 100 == 0)
            begin
                gap_pct <= 25 * $urandom_range(0, 2);
            end
            if (!item_bus.valid || item_taken)
            begin
                if (send_gap != 0 || number_words.size() == 0)
                begin
                    item_bus.valid <= 1'b0;
                    if (send_gap != 0)
                    begin
                        send_gap <= send_gap - 1;
                    end
                end
                else
                begin
                    next_word = number_words.pop_front();
                    item_bus.func         <= next_word.func;
                    item_bus.number       <= next_word.number;
                    item_bus.digit_count  <= next_word.digit_count;
                    item_bus.text_line    <= next_word.text_line;
                    item_bus.start_column <= next_word.start_column;
                    item_bus.valid        <= 1'b1;
                    if (number_words.size() >= CALM_WORDS
                        && $urandom_range(0, 99) < gap_pct)
                    begin
                        send_gap <= $urandom_range(1, 5);
                    end
                end
            end
            if (number_words.size() < CALM_WORDS)
            begin
                text_bus.ready <= 1'b1;
            end
            else if (recv_stall != 0)
            begin
                text_bus.ready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end
            else
            begin
                text_bus.ready <= 1'b1;
                if ($urandom_range(0, 99) < gap_pct)
                begin
                    recv_stall <= $urandom_range(1, 5);
                end
            end
        end
    end

    initial
    begin
        number_word_t w;
        int           pick;
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        item_bus.valid        = 1'b0;
        item_bus.func         = '0;
        item_bus.number       = '0;
        item_bus.digit_count  = '0;
        item_bus.text_line    = '0;
        item_bus.start_column = '0;
        text_bus.ready        = 1'b0;
        send_gap              = 0;
        recv_stall            = 0;
        gap_pct               = 25;
        tick                  = 0;
        mismatches            = 0;
        failures              = 0;

        add_word(MODE_UDEC, 32'hFFFF_FFFF, 6'd10, 3'd1, 5'd1);
        add_word(MODE_UDEC, 32'd1234567890, 6'd32, 3'd7, 5'd31);
        add_word(MODE_UDEC, 32'd0, 6'd1, 3'd0, 5'd0);
        add_word(MODE_SDEC, 32'h8000_0000, 6'd10, 3'd2, 5'd3);
        add_word(MODE_SDEC, 32'h7FFF_FFFF, 6'd12, 3'd4, 5'd16);
        add_word(MODE_SDEC, 32'hFFFF_FFFF, 6'd3, 3'd3, 5'd5);
        add_word(MODE_SDEC, 32'd0, 6'd1, 3'd1, 5'd1);
        add_word(MODE_SDEC, 32'd42, 6'd0, 3'd5, 5'd9);
        add_word(MODE_SDEC, 32'hFFFF_FF85, 6'd63, 3'd6, 5'd31);
        add_word(MODE_HEX, 32'hDEAD_BEEF, 6'd8, 3'd1, 5'd2);
        add_word(MODE_HEX, 32'h0123_4567, 6'd12, 3'd2, 5'd1);
        add_word(MODE_HEX, 32'h89AB_CDEF, 6'd32, 3'd0, 5'd0);
        add_word(MODE_HEX, 32'hFFFF_FFFF, 6'd0, 3'd3, 5'd4);
        add_word(MODE_BIN, 32'hFFFF_FFFF, 6'd32, 3'd4, 5'd1);
        add_word(MODE_BIN, 32'hA5A5_5A5A, 6'd40, 3'd7, 5'd31);
        add_word(MODE_BIN, 32'h0000_0001, 6'd1, 3'd1, 5'd16);
        add_word(MODE_BIN, 32'd0, 6'd0, 3'd2, 5'd2);
        add_word(MODE_UDEC, 32'd305419896, 6'd0, 3'd1, 5'd1);
        add_word(MODE_UDEC, 32'd9, 6'd33, 3'd3, 5'd30);

        for (int n = 0; n < 141; n++)
        begin
            w.func = mode_t'($urandom_range(0, 3));
            pick   = $urandom_range(0, 7);
            case (pick)
                0:       w.number = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF
                                    : (($urandom_range(0, 1) != 0) ? 32'h8000_0000
                                                                    : 32'h7FFF_FFFF);
                1:       w.number = $urandom_range(0, 999);
                2:       w.number = -$urandom_range(0, 999);
                3:       w.number = $urandom >> $urandom_range(0, 31);
                default: w.number = $urandom;
            endcase
            pick = $urandom_range(0, 19);
            case (pick)
                0:       w.digit_count = 6'd0;
                1:       w.digit_count = CNT_W'($urandom_range(33, 63));
                2, 3:    w.digit_count = CNT_W'($urandom_range(13, 32));
                default: w.digit_count = CNT_W'($urandom_range(1, 12));
            endcase
            w.text_line    = LINE_W'($urandom_range(0, 7));
            w.start_column = SCOL_W'($urandom_range(0, 31));
            number_words.push_back(w);
        end

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        while (number_words.size() != 0 || item_bus.valid)
        begin
            @(posedge clk);
        end
        while (owed_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (owed_chars.size() != 0)
        begin
            failures++;
        end
        if (failures == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
